>>> rtl/command_frame_receiver_top_macros.svh
// assertion helpers, clocked on clk and disabled during reset
`ifndef COMMAND_FRAME_RECEIVER_TOP_MACROS_SVH
`define COMMAND_FRAME_RECEIVER_TOP_MACROS_SVH

// same-cycle implication
`define CFR_ASSERT_NOW(lbl, cond, chk, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (chk)) \
		else $error(msg);

// next-cycle implication
`define CFR_ASSERT_NEXT(lbl, cond, chk, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (chk)) \
		else $error(msg);

`endif

>>> rtl/cfr_pkg.sv
package cfr_pkg;

	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_CODE = 8'd1;

	localparam logic [7:0] HEADER_RESET   = 8'hAA;
	localparam logic [7:0] FUNCTION_RESET = 8'hE0;
	localparam logic [7:0] ADDR_A         = 8'hAF;
	localparam logic [7:0] ADDR_B         = 8'hFF;
	localparam logic [7:0] GROUP_CAL      = 8'h01;
	localparam logic [7:0] GROUP_CTRL     = 8'h10;
	localparam logic [7:0] ITEM_CAL_FIRST = 8'h01;
	localparam logic [7:0] ITEM_CAL_LAST  = 8'h05;
	localparam logic [7:0] ITEM_UNLOCK    = 8'h01;
	localparam logic [7:0] ITEM_STOP      = 8'h02;

	typedef enum logic [2:0] {
		CMD_NONE       = 3'd0,
		CMD_ACCEL_CAL  = 3'd1,
		CMD_GYRO_CAL   = 3'd2,
		CMD_BARO_CAL   = 3'd3,
		CMD_MAG_CAL    = 3'd4,
		CMD_SIXSIDE_CAL = 3'd5,
		CMD_UNLOCK     = 3'd6,
		CMD_STOP       = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] function_code;
	} cfr_cfg_t;

	typedef struct packed {
		logic       fire;
		logic [7:0] rx_byte;
	} cfr_step_t;

	typedef struct packed {
		logic       frame_end;
		logic       checksum_ok;
		cmd_t       command;
		logic [7:0] echo_group;
		logic [7:0] echo_item;
	} cfr_result_t;

	function automatic cmd_t decode_cmd(logic [7:0] group, logic [7:0] item);
		cmd_t c;
		c = CMD_NONE;
		if (group == GROUP_CAL) begin
			if (item >= ITEM_CAL_FIRST && item <= ITEM_CAL_LAST)
				c = cmd_t'(item[2:0]);
		end else if (group == GROUP_CTRL) begin
			if (item == ITEM_UNLOCK)
				c = CMD_UNLOCK;
			else if (item == ITEM_STOP)
				c = CMD_STOP;
		end
		return c;
	endfunction

endpackage

>>> rtl/cfr_if.sv
interface cfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfr_res_if;
	logic       valid;
	logic       ready;
	logic       frame_end;
	logic       checksum_ok;
	logic [2:0] command;
	logic [7:0] echo_group;
	logic [7:0] echo_item;
	modport source (output valid, output frame_end, output checksum_ok, output command,
		output echo_group, output echo_item, input ready);
	modport sink (input valid, input frame_end, input checksum_ok, input command,
		input echo_group, input echo_item, output ready);
endinterface

interface cfr_cfg_if import cfr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/command_frame_receiver_top.sv
// command frame receiver
// rx channel: one received byte per transaction (rx_byte), valid/ready
// res channel: one result per accepted byte: frame_end, checksum_ok, command,
//   echo_group and echo_item; all but frame_end are zero unless a frame closed
//   with both the sum and add-check bytes matching
// cfg channel: index 0 writes header_byte, index 1 writes function_code,
//   other indexes are ignored; always ready, write only while idle
// path: an accepted byte waits in the input register, and its result is
//   written to the result register, which drives res, once that register
//   is empty or its result is being taken
// throughput: one byte per cycle while res takes every result, set by the
//   combinational frame state update between the input and result registers
// stall: when res is not taken the result register holds and the input
//   register still takes one more byte; rx ready drops only while both are full
// reset: arst_n clears the valid bits of both registers, the frame position,
//   sums and stored bytes, and loads header_byte 0xAA and function_code 0xE0
module command_frame_receiver_top import cfr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	cfr_rx_if.sink        rx,
	cfr_res_if.source     res,
	cfr_cfg_if.sink       cfg
);

	cfr_cfg_t    cfg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	cfr_result_t result_s2;
	cfr_result_t result;
	cfr_step_t   step;
	logic        advance;

	assign advance      = valid_s1 && (!valid_s2 || res.ready);
	assign rx.ready     = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;
	assign step.fire    = advance;
	assign step.rx_byte = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte   <= HEADER_RESET;
			cfg_q.function_code <= FUNCTION_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_HEADER_BYTE)
				cfg_q.header_byte <= cfg.data;
			else if (cfg.index == REG_FUNCTION_CODE)
				cfg_q.function_code <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rx.valid && rx.ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (res.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.rx_byte;
		if (advance)
			result_s2 <= result;
	end

	cfr_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.result (result)
	);

	assign res.valid       = valid_s2;
	assign res.frame_end   = result_s2.frame_end;
	assign res.checksum_ok = result_s2.checksum_ok;
	assign res.command     = result_s2.command;
	assign res.echo_group  = result_s2.echo_group;
	assign res.echo_item   = result_s2.echo_item;

endmodule

>>> rtl/cfr_parser.sv
`include "command_frame_receiver_top_macros.svh"

module cfr_parser import cfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfr_step_t   step,
	input  cfr_cfg_t    cfg,
	output cfr_result_t result
);

	logic [8:0] position_q;
	logic [7:0] length_q;
	logic [7:0] sum_q;
	logic [7:0] add_check_q;
	logic [7:0] rx_sum_q;
	logic [7:0] byte_four_q;
	logic [7:0] byte_six_q;

	logic [8:0] position_d;
	logic [7:0] length_d;
	logic [7:0] sum_d;
	logic [7:0] add_check_d;
	logic [7:0] rx_sum_d;
	logic [7:0] byte_four_d;
	logic [7:0] byte_six_d;

	logic [7:0] b;
	logic [7:0] sum_next;
	logic [7:0] add_next;
	logic [8:0] len9;
	logic       at_body;

	assign b        = step.rx_byte;
	assign sum_next = sum_q + b;
	assign add_next = add_check_q + sum_next;
	assign len9     = {1'b0, length_q};
	assign at_body  = (position_q >= 9'd4);

	always_comb begin
		position_d  = 9'd0;
		length_d    = length_q;
		sum_d       = sum_q;
		add_check_d = add_check_q;
		rx_sum_d    = rx_sum_q;
		byte_four_d = byte_four_q;
		byte_six_d  = byte_six_q;
		result      = '{frame_end: 1'b0, checksum_ok: 1'b0, command: CMD_NONE,
			echo_group: 8'd0, echo_item: 8'd0};

		if (at_body && position_q == 9'd4)
			byte_four_d = b;
		if (at_body && position_q == 9'd6)
			byte_six_d = b;

		if (position_q == 9'd0 && b == cfg.header_byte) begin
			sum_d       = b;
			add_check_d = b;
			position_d  = 9'd1;
		end else if (position_q == 9'd1 && (b == ADDR_A || b == ADDR_B)) begin
			sum_d       = sum_next;
			add_check_d = add_next;
			position_d  = 9'd2;
		end else if (position_q == 9'd2 && b == cfg.function_code) begin
			sum_d       = sum_next;
			add_check_d = add_next;
			position_d  = 9'd3;
		end else if (position_q == 9'd3) begin
			length_d    = b;
			sum_d       = sum_next;
			add_check_d = add_next;
			position_d  = 9'd4;
		end else if (at_body && length_q != 8'd0 && position_q <= len9 + 9'd3) begin
			sum_d       = sum_next;
			add_check_d = add_next;
			position_d  = position_q + 9'd1;
		end else if (at_body && position_q == len9 + 9'd4) begin
			rx_sum_d   = b;
			position_d = position_q + 9'd1;
		end else if (at_body && position_q == len9 + 9'd5) begin
			result.frame_end = 1'b1;
			if (rx_sum_q == sum_q && b == add_check_q) begin
				result.checksum_ok = 1'b1;
				result.command     = decode_cmd(byte_four_d, byte_six_d);
				result.echo_group  = byte_four_d;
				result.echo_item   = byte_six_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= 9'd0;
			length_q    <= 8'd0;
			sum_q       <= 8'd0;
			add_check_q <= 8'd0;
			rx_sum_q    <= 8'd0;
			byte_four_q <= 8'd0;
			byte_six_q  <= 8'd0;
		end else if (step.fire) begin
			position_q  <= position_d;
			length_q    <= length_d;
			sum_q       <= sum_d;
			add_check_q <= add_check_d;
			rx_sum_q    <= rx_sum_d;
			byte_four_q <= byte_four_d;
			byte_six_q  <= byte_six_d;
		end
	end

	`CFR_ASSERT_NEXT(a_end_restarts, step.fire && result.frame_end, position_q == 9'd0,
		"frame end did not return to start")
	`CFR_ASSERT_NEXT(a_idle_holds, !step.fire, $stable(position_q) && $stable(sum_q),
		"frame state moved without a byte")
	`CFR_ASSERT_NOW(a_ok_at_end, result.checksum_ok, result.frame_end && at_body,
		"checksum ok outside a frame end")
	`CFR_ASSERT_NOW(a_position_bound, 1'b1, position_q <= 9'd260,
		"frame position out of range")

endmodule

>>> bench/command_frame_receiver_top_test.sv
`timescale 1ns / 100ps

module command_frame_receiver_top_test;
	import cfr_pkg::*;

	localparam int IDLE_PCT = 22;
	localparam int HOLD_CYCLES = 80;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_FUNCTION_CODE + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = {CFG_IDX_W{1'b1}};

	typedef enum int {
		FLAW_NONE,
		FLAW_SUM,
		FLAW_ADD,
		FLAW_CUT,
		FLAW_ADDR,
		FLAW_FUNC
	} frame_flaw_t;

	logic clk = 1'b0;
	logic arst_n;

	cfr_rx_if rx_ch();
	cfr_res_if res_ch();
	cfr_cfg_if cfg_ch();

	command_frame_receiver_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// receiver state as the block should hold it
	logic [7:0] hdr_cfg = HEADER_RESET;
	logic [7:0] func_cfg = FUNCTION_RESET;
	logic [8:0] at_pos = '0;
	logic [7:0] pay_len = '0;
	logic [7:0] sum_acc = '0;
	logic [7:0] add_acc = '0;
	logic [7:0] sum_rx = '0;
	logic [7:0] grp_keep = '0;
	logic [7:0] itm_keep = '0;

	logic [7:0] rx_bytes_pending[$];
	cfr_result_t outcomes_due[$];
	cfr_result_t want;
	cfr_result_t got;
	int mismatches = 0;
	int seen_results = 0;
	int hold_left;
	bit hold_done;
	bit steady;

	function automatic cfr_result_t frame_byte_outcome(logic [7:0] b);
		cfr_result_t r;
		logic [8:0] len;
		r = '0;
		len = {1'b0, pay_len};
		if (at_pos == 9'd4)
			grp_keep = (len > 0 || at_pos <= 9'd5) ? b : grp_keep;
		if (at_pos == 9'd0 && b == hdr_cfg) begin
			sum_acc = b;
			add_acc = b;
			at_pos = 9'd1;
		end else if (at_pos == 9'd1 && (b == ADDR_A || b == ADDR_B)) begin
			sum_acc = sum_acc + b;
			add_acc = add_acc + sum_acc;
			at_pos = 9'd2;
		end else if (at_pos == 9'd2 && b == func_cfg) begin
			sum_acc = sum_acc + b;
			add_acc = add_acc + sum_acc;
			at_pos = 9'd3;
		end else if (at_pos == 9'd3) begin
			pay_len = b;
			sum_acc = sum_acc + b;
			add_acc = add_acc + sum_acc;
			at_pos = 9'd4;
		end else if (at_pos >= 9'd4 && len > 0 && at_pos <= 9'd3 + len) begin
			if (at_pos == 9'd6)
				itm_keep = b;
			sum_acc = sum_acc + b;
			add_acc = add_acc + sum_acc;
			at_pos = at_pos + 9'd1;
		end else if (at_pos >= 9'd4 && at_pos == 9'd4 + len) begin
			if (at_pos == 9'd6)
				itm_keep = b;
			sum_rx = b;
			at_pos = at_pos + 9'd1;
		end else if (at_pos >= 9'd4 && at_pos == 9'd5 + len) begin
			if (at_pos == 9'd6)
				itm_keep = b;
			r.frame_end = 1'b1;
			if (sum_rx == sum_acc && b == add_acc) begin
				r.checksum_ok = 1'b1;
				r.echo_group = grp_keep;
				r.echo_item = itm_keep;
				if (grp_keep == GROUP_CAL && itm_keep >= ITEM_CAL_FIRST
						&& itm_keep <= ITEM_CAL_LAST)
					r.command = cmd_t'(CMD_ACCEL_CAL + (itm_keep - ITEM_CAL_FIRST));
				else if (grp_keep == GROUP_CTRL && itm_keep == ITEM_UNLOCK)
					r.command = CMD_UNLOCK;
				else if (grp_keep == GROUP_CTRL && itm_keep == ITEM_STOP)
					r.command = CMD_STOP;
			end
			at_pos = 9'd0;
		end else begin
			at_pos = 9'd0;
		end
		return r;
	endfunction

	// byte at position 4 is stored whatever branch takes it; it is never dropped
	// (handled above: position 4 is always a payload or sum byte)

	task automatic push_frame(int len, logic [7:0] group, logic [7:0] item,
			frame_flaw_t flaw);
		logic [7:0] frame[$];
		logic [7:0] s;
		logic [7:0] a;
		logic [7:0] bad;
		int keep;
		frame.push_back(hdr_cfg);
		frame.push_back($urandom_range(1) ? ADDR_A : ADDR_B);
		frame.push_back(func_cfg);
		frame.push_back(8'(len));
		for (int i = 0; i < len; i++)
			frame.push_back(i == 0 ? group : (i == 2 ? item : 8'($urandom_range(255))));
		s = '0;
		a = '0;
		foreach (frame[i]) begin
			s = s + frame[i];
			a = a + s;
		end
		frame.push_back(s);
		frame.push_back(a);
		case (flaw)
			FLAW_SUM: frame[4 + len] ^= 8'($urandom_range(1, 255));
			FLAW_ADD: frame[5 + len] ^= 8'($urandom_range(1, 255));
			FLAW_FUNC: frame[2] ^= 8'($urandom_range(1, 255));
			FLAW_ADDR: begin
				do bad = 8'($urandom_range(255)); while (bad == ADDR_A || bad == ADDR_B);
				frame[1] = bad;
			end
			FLAW_CUT: begin
				keep = $urandom_range(1, len + 5);
				while (frame.size() > keep)
					void'(frame.pop_back());
			end
			default: ;
		endcase
		foreach (frame[i])
			rx_bytes_pending.push_back(frame[i]);
	endtask

	task automatic random_burst(int budget);
		int pick;
		int len;
		logic [7:0] group;
		logic [7:0] item;
		while (rx_bytes_pending.size() < budget) begin
			pick = $urandom_range(99);
			len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
			case ($urandom_range(3))
				0, 1: group = GROUP_CAL;
				2: group = GROUP_CTRL;
				default: group = 8'($urandom_range(255));
			endcase
			item = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
			if (pick < 65)
				push_frame(len, group, item, FLAW_NONE);
			else if (pick < 85)
				push_frame(len, group, item, frame_flaw_t'($urandom_range(FLAW_SUM, FLAW_FUNC)));
			else
				repeat ($urandom_range(1, 4))
					rx_bytes_pending.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_HEADER_BYTE: hdr_cfg = val;
			REG_FUNCTION_CODE: func_cfg = val;
			default: ;
		endcase
	endtask

	task automatic drain_outcomes();
		do @(posedge clk); while (rx_bytes_pending.size() != 0 || outcomes_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
			rx_ch.rx_byte <= '0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				outcomes_due.push_back(frame_byte_outcome(rx_ch.rx_byte));
				void'(rx_bytes_pending.pop_front());
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				if (rx_bytes_pending.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					rx_ch.valid <= 1'b1;
					rx_ch.rx_byte <= rx_bytes_pending[0];
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got.frame_end = res_ch.frame_end;
				got.checksum_ok = res_ch.checksum_ok;
				got.command = cmd_t'(res_ch.command);
				got.echo_group = res_ch.echo_group;
				got.echo_item = res_ch.echo_item;
				if (outcomes_due.size() == 0) begin
					$display("%0t: unexpected transaction: expected none, actual end=%0b ok=%0b cmd=%0d group=%02h item=%02h",
						$time, got.frame_end, got.checksum_ok, got.command,
						got.echo_group, got.echo_item);
					mismatches++;
				end else begin
					want = outcomes_due.pop_front();
					if (got !== want) begin
						$display("%0t: expected end=%0b ok=%0b cmd=%0d group=%02h item=%02h, actual end=%0b ok=%0b cmd=%0d group=%02h item=%02h",
							$time, want.frame_end, want.checksum_ok, want.command,
							want.echo_group, want.echo_item, got.frame_end, got.checksum_ok,
							got.command, got.echo_group, got.echo_item);
						mismatches++;
					end
				end
				seen_results <= seen_results + 1;
			end
			res_ch.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
		end
	end

	// one long receiver hold-off, and a stretch with no idling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
			steady <= 1'b0;
		end else begin
			if (!hold_done && seen_results >= 100) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
			steady <= seen_results >= 300 && seen_results < 500;
		end
	end

	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: good frame, zero length (sum byte as group, stale item), bad sum, extremes
		push_frame(3, GROUP_CAL, ITEM_CAL_FIRST, FLAW_NONE);
		push_frame(0, '0, '0, FLAW_NONE);
		push_frame(0, '0, '0, FLAW_SUM);
		rx_bytes_pending.push_back(8'h00);
		rx_bytes_pending.push_back(8'hFF);
		random_burst(140);
		drain_outcomes();

		write_reg(REG_HEADER_BYTE, 8'h00);
		write_reg(REG_FUNCTION_CODE, 8'h00);
		write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_INDEX)),
			8'($urandom_range(255)));
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
		random_burst(120);
		drain_outcomes();

		write_reg(REG_HEADER_BYTE, 8'hFF);
		write_reg(REG_FUNCTION_CODE, 8'hFF);
		write_reg(REG_LAST_INDEX, 8'h00);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
		random_burst(120);
		drain_outcomes();

		write_reg(REG_FUNCTION_CODE, 8'($urandom_range(255)));
		write_reg(REG_HEADER_BYTE, 8'($urandom_range(255)));
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
		push_frame(255, GROUP_CTRL, ITEM_STOP, FLAW_NONE);
		random_burst(380);
		drain_outcomes();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
